[hdl/fspa_pkg.sv]
// Package for the fixed-slot pool allocator.
// Holds the transfer payload types, outcome codes and controller states.
// No dependencies.
package fspa_pkg;

  // Actions of an input transfer.
  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  // Outcome codes of a result transfer.
  localparam logic [2:0] OUT_GRANTED = 3'd0;
  localparam logic [2:0] OUT_FULL    = 3'd1;
  localparam logic [2:0] OUT_SHRINK  = 3'd2;
  localparam logic [2:0] OUT_LISTED  = 3'd3;
  localparam logic [2:0] OUT_IGNORED = 3'd4;

  // Width and reset value of the slot count register.
  localparam int unsigned SLOT_COUNT_W = 9;
  localparam logic [SLOT_COUNT_W-1:0] SLOT_COUNT_RST = 9'd256;

  typedef struct packed {
    logic       action;
    logic [7:0] slot_in;
  } in_item_t;

  typedef struct packed {
    logic [2:0] outcome;
    logic [7:0] slot_out;
  } out_item_t;

  typedef enum logic {
    ST_IDLE,
    ST_POP
  } ctrl_state_t;

endpackage

[hdl/fspa_link_ram.sv]
// Link memory of the free list: one write port, one read port,
// read data registered. Depends on nothing.
module fspa_link_ram #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned WIDTH = 9
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[hdl/fixed_slot_pool_allocator_unit.sv]
// Top level of the fixed-slot pool allocator: free-list head, bump counter,
// controller and output register. Depends on fspa_pkg and fspa_link_ram.
//
//   channel  | ports                         | payload
//   ---------+-------------------------------+----------------------------
//   input    | in_valid, in_stall, in_item   | action, slot_in
//   result   | out_valid, out_stall, out_item| outcome, slot_out
//   config   | cfg_wr_en, cfg_wr_data        | slot_count (9 bits)
//
// An allocate served from the free list passes through ST_POP: the head's link is
// read from the synchronous link RAM before the head can move. Every other transfer
// is finished in ST_IDLE. An input transfer is taken while the controller is idle
// and the output register is empty or being drained in the same cycle. Reset empties
// the list, clears the bump counter and sets the slot count to its reset value; link
// entries are meaningful only after a free wrote them, so there is no clearing pass.
module fixed_slot_pool_allocator_unit
  import fspa_pkg::*;
#(
  parameter int unsigned SLOTS = 256
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  in_item_t                in_item,
  output logic                    out_valid,
  input  logic                    out_stall,
  output out_item_t               out_item,
  input  logic                    cfg_wr_en,
  input  logic [SLOT_COUNT_W-1:0] cfg_wr_data
);

  localparam int unsigned IDX_W  = $clog2(SLOTS);
  localparam int unsigned LINK_W = $clog2(SLOTS + 1);
  localparam int unsigned CNT_W  = (LINK_W > SLOT_COUNT_W) ? LINK_W : SLOT_COUNT_W;

  ctrl_state_t             state_r, state_nxt;
  logic [LINK_W-1:0]       head_r, head_nxt;
  logic [LINK_W-1:0]       bump_r, bump_nxt;
  logic [SLOT_COUNT_W-1:0] cnt_r;
  logic                    out_valid_r, out_valid_nxt;
  out_item_t               out_item_r, out_item_nxt;

  logic              out_free;
  logic              in_accept;
  logic              head_empty;
  logic [CNT_W-1:0]  cnt_ext;
  logic [CNT_W-1:0]  cap;
  logic [CNT_W-1:0]  slot_ext;
  logic [CNT_W-1:0]  bump_ext;
  logic              ram_wr_en;
  logic              ram_rd_en;
  logic [LINK_W-1:0] ram_rd_data;

  // Effective slot count is capped at the pool size.
  assign cnt_ext    = CNT_W'(cnt_r);
  assign cap        = (cnt_ext > CNT_W'(SLOTS)) ? CNT_W'(SLOTS) : cnt_ext;
  assign slot_ext   = CNT_W'(in_item.slot_in);
  assign bump_ext   = CNT_W'(bump_r);
  assign head_empty = (head_r >= LINK_W'(SLOTS));

  // Handshake: take a transfer when idle and the result has somewhere to go.
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE) || !out_free;
  assign in_accept = in_valid && !in_stall;

  // Link memory: a free writes the old head into the freed slot's entry,
  // an allocate from the list reads the head's entry.
  fspa_link_ram #(
    .DEPTH (SLOTS),
    .WIDTH (LINK_W)
  ) u_link_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (IDX_W'(in_item.slot_in)),
    .wr_data (head_r),
    .rd_en   (ram_rd_en),
    .rd_addr (IDX_W'(head_r)),
    .rd_data (ram_rd_data)
  );

  // Next state, pointer updates and result.
  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    bump_nxt      = bump_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_item_nxt  = out_item_r;
    ram_wr_en     = 1'b0;
    ram_rd_en     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          if (in_item.action == ACT_ALLOC) begin
            if (!head_empty) begin
              ram_rd_en = 1'b1;
              state_nxt = ST_POP;
            end else if (bump_ext < cap) begin
              out_valid_nxt         = 1'b1;
              out_item_nxt.outcome  = OUT_GRANTED;
              out_item_nxt.slot_out = 8'(bump_r);
              bump_nxt              = bump_r + LINK_W'(1);
            end else begin
              out_valid_nxt         = 1'b1;
              out_item_nxt.outcome  = OUT_FULL;
              out_item_nxt.slot_out = 8'd0;
            end
          end else begin
            out_valid_nxt         = 1'b1;
            out_item_nxt.slot_out = 8'd0;
            if (slot_ext >= cap) begin
              out_item_nxt.outcome = OUT_IGNORED;
            end else if ((bump_r != '0) && (slot_ext + CNT_W'(1) == bump_ext)) begin
              out_item_nxt.outcome = OUT_SHRINK;
              bump_nxt             = bump_r - LINK_W'(1);
            end else begin
              out_item_nxt.outcome = OUT_LISTED;
              ram_wr_en            = 1'b1;
              head_nxt             = LINK_W'(slot_ext);
            end
          end
        end
      end
      ST_POP: begin
        // Link data is ready; hand out the head once the output can take it.
        if (out_free) begin
          out_valid_nxt         = 1'b1;
          out_item_nxt.outcome  = OUT_GRANTED;
          out_item_nxt.slot_out = 8'(head_r);
          head_nxt              = ram_rd_data;
          state_nxt             = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= LINK_W'(SLOTS);
      bump_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      bump_r      <= bump_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Slot count register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= SLOT_COUNT_RST;
    end else if (cfg_wr_en) begin
      cnt_r <= cfg_wr_data;
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

`ifndef NO_ASSERTIONS
  // The bump counter never passes the pool size.
  assert property (@(posedge clk) disable iff (!rst_n) bump_r <= LINK_W'(SLOTS))
    else $error("bump counter beyond pool size");

  // An allocate with a non-empty list goes through the link read.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_item.action == ACT_ALLOC && !head_empty) |=> state_r == ST_POP)
    else $error("list allocate skipped the link read");

  // A bump shrink lowers the counter by exactly one.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_item.action == ACT_FREE && slot_ext < cap && bump_r != '0 &&
     slot_ext + CNT_W'(1) == bump_ext) |=> bump_r == $past(bump_r) - LINK_W'(1))
    else $error("bump shrink did not lower the counter");

  // A list push makes the freed slot the new head.
  assert property (@(posedge clk) disable iff (!rst_n)
    (ram_wr_en) |=> head_r == LINK_W'($past(slot_ext)))
    else $error("freed slot is not the new head");

  // Only grants carry a slot index.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r.outcome != OUT_GRANTED) |-> out_item_r.slot_out == 8'd0)
    else $error("non-grant result with a slot index");
`endif

endmodule

[tb/sv/fixed_slot_pool_allocator_unit_tb.sv]
// Self-checking testbench for fixed_slot_pool_allocator_unit.
// Depends on fspa_pkg and the allocator RTL; predicts each outcome from its own pool model
// and checks every result transfer against it, under random idling on both channels.
module fixed_slot_pool_allocator_unit_tb;
  import fspa_pkg::*;

  localparam int POOL_SLOTS  = 256;
  localparam int QUIET_LIMIT = 5000;
  localparam int HOLD_CYCLES = 300;

  logic                    clk;
  logic                    rst_n       = 1'b0;
  logic                    in_valid    = 1'b0;
  logic                    in_stall;
  in_item_t                in_item     = '0;
  logic                    out_valid;
  logic                    out_stall   = 1'b0;
  out_item_t               out_item;
  logic                    cfg_wr_en   = 1'b0;
  logic [SLOT_COUNT_W-1:0] cfg_wr_data = '0;

  // Pool model state: per-slot links, list head, bump top and the slot count register.
  logic [8:0] link_mem [POOL_SLOTS];
  logic [8:0] list_head = 9'(POOL_SLOTS);
  logic [8:0] bump_top  = 9'd0;
  logic [8:0] count_cfg = SLOT_COUNT_RST;

  // Slots the stimulus believes it holds, and which slots sit on the free list.
  logic [7:0] held_slots[$];
  bit         on_list [POOL_SLOTS];

  out_item_t expected_outcomes[$];
  int        fail_count    = 0;
  int        quiet_cycles  = 0;
  int        snd_idle_pct  = 0;
  int        rcv_idle_pct  = 0;
  int        hold_requests = 0;
  int        holds_served  = 0;
  int        hold_left     = 0;

  fixed_slot_pool_allocator_unit #(
    .SLOTS(POOL_SLOTS)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Advances the pool model by one accepted request and returns the outcome it gives.
  function automatic out_item_t predict_pool_outcome(in_item_t req);
    out_item_t  res;
    logic [8:0] cap;
    cap = (count_cfg > 9'(POOL_SLOTS)) ? 9'(POOL_SLOTS) : count_cfg;
    res.outcome  = OUT_FULL;
    res.slot_out = '0;
    if (req.action == ACT_ALLOC) begin
      // The free list has priority over the bump counter.
      if (list_head < 9'(POOL_SLOTS)) begin
        res.outcome  = OUT_GRANTED;
        res.slot_out = list_head[7:0];
        list_head    = link_mem[list_head[7:0]];
      end else if (bump_top < cap) begin
        res.outcome  = OUT_GRANTED;
        res.slot_out = bump_top[7:0];
        bump_top     = bump_top + 9'd1;
      end
    end else if ({1'b0, req.slot_in} >= cap) begin
      res.outcome = OUT_IGNORED;
    end else if (bump_top != 9'd0 && {1'b0, req.slot_in} == bump_top - 9'd1) begin
      res.outcome = OUT_SHRINK;
      bump_top    = bump_top - 9'd1;
    end else begin
      res.outcome            = OUT_LISTED;
      link_mem[req.slot_in]  = list_head;
      list_head              = {1'b0, req.slot_in};
    end
    return res;
  endfunction

  // Offers one request, waits for its transfer, then records the expected outcome.
  task automatic send_item(input logic act, input logic [7:0] slot);
    in_item_t  req;
    out_item_t want;
    int        found[$];
    req.action  = act;
    req.slot_in = slot;
    if ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < snd_idle_pct);
    end
    in_valid <= 1'b1;
    in_item  <= req;
    do @(posedge clk); while (in_stall);
    want = predict_pool_outcome(req);
    expected_outcomes.push_back(want);
    // Keep the stimulus view of held and listed slots in step with the model.
    case (want.outcome)
      OUT_GRANTED: begin
        held_slots.push_back(want.slot_out);
        on_list[want.slot_out] = 1'b0;
      end
      OUT_SHRINK, OUT_LISTED: begin
        found = held_slots.find_first_index(x) with (x == slot);
        if (found.size() != 0) held_slots.delete(found[0]);
        if (want.outcome == OUT_LISTED) on_list[slot] = 1'b1;
      end
      default: ;
    endcase
  endtask

  // Writes the slot count once the block has drained.
  task automatic write_slot_count(input logic [8:0] value);
    in_valid <= 1'b0;
    while (expected_outcomes.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    count_cfg = value;
  endtask

  // Mostly frees of held slots and allocates; some frees of the bump top and some
  // random indexes. Slots already on the list are never freed here, so the list
  // stays free of loops until the double-free test.
  function automatic in_item_t next_random_item(int alloc_pct);
    in_item_t   req;
    int         pick;
    logic [7:0] slot;
    req.action  = ACT_ALLOC;
    req.slot_in = 8'($urandom);
    if ($urandom_range(99) >= alloc_pct) begin
      pick = $urandom_range(99);
      if (held_slots.size() != 0 && pick < 70) begin
        slot = held_slots[$urandom_range(held_slots.size() - 1)];
      end else if (bump_top != 9'd0 && pick < 85) begin
        slot = 8'(bump_top - 9'd1);
      end else begin
        slot = 8'($urandom);
      end
      if (!on_list[slot]) begin
        req.action  = ACT_FREE;
        req.slot_in = slot;
      end
    end
    return req;
  endfunction

  // Allocates from bump, shrinks, lists, pops from the list and frees the top slot.
  task automatic test_reset_state();
    send_item(ACT_ALLOC, 8'd0);
    send_item(ACT_ALLOC, 8'd255);
    send_item(ACT_ALLOC, 8'd0);
    send_item(ACT_FREE, 8'd2);
    send_item(ACT_FREE, 8'd0);
    send_item(ACT_ALLOC, 8'd0);
    send_item(ACT_FREE, 8'd255);
    send_item(ACT_ALLOC, 8'd0);
  endtask

  // A two-slot pool: full pool, frees outside the pool, shrink to zero and a
  // free of a slot above the bump top.
  task automatic test_small_pool();
    write_slot_count(9'd2);
    send_item(ACT_ALLOC, 8'd0);
    send_item(ACT_FREE, 8'd255);
    send_item(ACT_FREE, 8'd2);
    send_item(ACT_FREE, 8'd1);
    send_item(ACT_FREE, 8'd0);
    send_item(ACT_FREE, 8'd1);
    send_item(ACT_ALLOC, 8'd0);
    send_item(ACT_ALLOC, 8'd0);
  endtask

  // The largest register value acts as a full pool.
  task automatic test_count_above_pool();
    write_slot_count(9'd511);
    send_item(ACT_FREE, 8'd255);
    send_item(ACT_ALLOC, 8'd0);
  endtask

  // A listed slot is still granted after the slot count drops to zero.
  task automatic test_count_lowered();
    send_item(ACT_FREE, 8'd1);
    write_slot_count(9'd0);
    send_item(ACT_ALLOC, 8'd0);
    send_item(ACT_ALLOC, 8'd0);
    send_item(ACT_FREE, 8'd0);
  endtask

  // Random traffic at one slot count, alternating fill-heavy and drain-heavy windows.
  task automatic test_random_traffic(input int count, input logic [8:0] slots);
    in_item_t req;
    write_slot_count(slots);
    for (int i = 0; i < count; i++) begin
      req = next_random_item(((i / 48) % 2 == 0) ? 70 : 30);
      send_item(req.action, req.slot_in);
    end
  endtask

  // The receiver holds off for a long stretch while requests keep coming.
  task automatic test_stalled_output();
    in_item_t req;
    write_slot_count(9'd256);
    hold_requests++;
    for (int i = 0; i < 40; i++) begin
      req = next_random_item(50);
      send_item(req.action, req.slot_in);
    end
  endtask

  // Freeing a listed slot again makes the list loop on that slot.
  task automatic test_double_free();
    logic [7:0] slot;
    write_slot_count(9'd256);
    slot = (bump_top == 9'd1) ? 8'd1 : 8'd0;
    send_item(ACT_FREE, slot);
    send_item(ACT_FREE, slot);
    send_item(ACT_ALLOC, 8'd0);
    send_item(ACT_ALLOC, 8'd0);
  endtask

  // Result receiver: random stalls, or a counted hold when one is requested.
  always @(posedge clk) begin
    if (hold_requests != holds_served) begin
      holds_served = hold_requests;
      hold_left    = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rcv_idle_pct);
    end
  end

  // Compare each result transfer with the oldest expected outcome.
  always @(posedge clk) begin : check_outcomes
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_outcomes.size() == 0) begin
        $display("%0t: unexpected result, actual outcome %0d slot %0d",
                 $time, out_item.outcome, out_item.slot_out);
        fail_count++;
      end else begin
        want = expected_outcomes.pop_front();
        if (out_item.outcome !== want.outcome) begin
          $display("%0t: outcome mismatch, expected %0d, actual %0d",
                   $time, want.outcome, out_item.outcome);
          fail_count++;
        end
        if (out_item.slot_out !== want.slot_out) begin
          $display("%0t: slot_out mismatch, expected %0d, actual %0d",
                   $time, want.slot_out, out_item.slot_out);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    foreach (link_mem[i]) link_mem[i] = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Sender idles lightly, receiver heavily.
    snd_idle_pct = 34;
    rcv_idle_pct = 81;
    test_reset_state();
    test_small_pool();
    test_count_above_pool();
    test_count_lowered();
    test_random_traffic(300, 9'd256);
    test_random_traffic(200, 9'd16);
    test_random_traffic(150, 9'd511);

    // Sender idles heavily, receiver lightly.
    snd_idle_pct = 81;
    rcv_idle_pct = 34;
    test_random_traffic(100, 9'd1);
    test_random_traffic(50, 9'd0);
    test_random_traffic(200, 9'd300);
    test_random_traffic(300, 9'($urandom_range(511)));

    // No idling on either side.
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    test_random_traffic(250, 9'd64);
    test_random_traffic(100, 9'd2);
    test_random_traffic(300, 9'd256);
    test_stalled_output();
    test_double_free();

    in_valid <= 1'b0;
    while (expected_outcomes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
